[design/i2cbe_pkg.sv]
// shared types, op codes and slot plan constants of the i2c master bit engine
`timescale 1ns / 1ps

package i2cbe_pkg;

    // stream word widths, whole bytes
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

    // command codes, idle marks no command running
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_WACK  = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_SACK  = 3'd4;
    localparam logic [2:0] OP_STOP  = 3'd5;
    localparam logic [2:0] OP_IDLE  = 3'd7;

    // write bit phases: data setup, clock high, clock low
    localparam logic [1:0] PH_SETUP = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;

    // engine state carried between slots
    typedef struct packed {
        logic [2:0] cmd;
        logic [4:0] slot;
        logic [1:0] phase;
        logic [7:0] shift;
        logic [7:0] tx;
        logic       scl;
        logic       sda;
        logic       sda_en;
        logic       ack;
    } t_state;

    // input word fields
    typedef struct packed {
        logic       sda_in;
        logic       ack_bit;
        logic [7:0] write_data;
        logic [2:0] op;
        logic       cmd_valid;
    } t_slot_in;

    // result word fields
    typedef struct packed {
        logic       ack_received;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_level;
        logic       scl_level;
    } t_result;

    // index of the last slot of each command
    function automatic logic [4:0] last_slot(input logic [2:0] cmd);
        logic [4:0] r;
        r = 5'd0;
        case (cmd)
            OP_START: r = 5'd1;
            OP_WRITE: r = 5'd24;
            OP_WACK:  r = 5'd1;
            OP_READ:  r = 5'd16;
            OP_SACK:  r = 5'd2;
            OP_STOP:  r = 5'd2;
            default:  r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

[design/i2cbe_step.sv]
// slot sequencer: next engine state and result of one timing slot
`timescale 1ns / 1ps

module i2cbe_step (
    input  i2cbe_pkg::t_state   i_state,
    input  i2cbe_pkg::t_slot_in i_slot,
    output i2cbe_pkg::t_state   o_state,
    output i2cbe_pkg::t_result  o_result
);
    import i2cbe_pkg::*;

    t_state     n;
    logic       take;
    logic       busy;
    logic       done;
    logic [1:0] ph;

    always_comb begin
        n    = i_state;
        busy = 1'b0;
        done = 1'b0;
        ph   = 2'd0;

        // accept a command only when idle and the code is known
        take = (i_state.cmd == OP_IDLE) && i_slot.cmd_valid && (i_slot.op <= OP_STOP);
        if (take) begin
            n.cmd   = i_slot.op;
            n.slot  = 5'd0;
            n.phase = PH_SETUP;
            n.tx    = (i_slot.op == OP_SACK) ? {7'd0, i_slot.ack_bit} : i_slot.write_data;
            if (i_slot.op == OP_READ) begin
                n.shift = 8'd0;
            end
        end

        ph = n.phase;

        // pin plan of the current slot
        if (n.cmd != OP_IDLE) begin
            busy = 1'b1;
            case (n.cmd)
                OP_START: begin
                    if (n.slot == 5'd0) begin
                        n.sda_en = 1'b1;
                        n.sda    = 1'b1;
                        n.scl    = 1'b1;
                    end else begin
                        n.sda = 1'b0;
                    end
                end
                OP_WRITE: begin
                    if (n.slot == 5'd0) begin
                        n.sda_en = 1'b1;
                        n.scl    = 1'b0;
                    end else begin
                        case (ph)
                            PH_SETUP: begin
                                n.sda = n.tx[7];
                                n.tx  = {n.tx[6:0], 1'b0};
                                n.scl = 1'b0;
                            end
                            PH_HIGH: n.scl = 1'b1;
                            default: n.scl = 1'b0;
                        endcase
                        n.phase = (ph == PH_LOW) ? PH_SETUP : ph + 2'd1;
                    end
                end
                OP_WACK: begin
                    if (n.slot == 5'd0) begin
                        n.sda_en = 1'b0;
                        n.scl    = 1'b0;
                    end else begin
                        n.scl = 1'b1;
                        n.ack = ~i_slot.sda_in;
                    end
                end
                OP_READ: begin
                    if (n.slot == 5'd0) begin
                        n.sda_en = 1'b0;
                        n.scl    = 1'b0;
                    end else if (n.slot[0]) begin
                        n.scl   = 1'b1;
                        n.shift = {n.shift[6:0], i_slot.sda_in};
                    end else begin
                        n.scl = 1'b0;
                    end
                end
                OP_SACK: begin
                    if (n.slot == 5'd0) begin
                        n.sda_en = 1'b1;
                        n.scl    = 1'b0;
                    end else if (n.slot == 5'd1) begin
                        n.sda = n.tx[0];
                    end else begin
                        n.scl = 1'b1;
                    end
                end
                OP_STOP: begin
                    if (n.slot == 5'd0) begin
                        n.sda_en = 1'b1;
                        n.scl    = 1'b0;
                        n.sda    = 1'b0;
                    end else if (n.slot == 5'd1) begin
                        n.scl = 1'b1;
                    end else begin
                        n.sda = 1'b1;
                    end
                end
                default: begin
                    n.scl = n.scl;
                end
            endcase
            done = (n.slot >= last_slot(n.cmd));
        end

        // result shows the pins of this slot
        o_result.scl_level    = n.scl;
        o_result.sda_level    = n.sda;
        o_result.sda_drive    = n.sda_en;
        o_result.busy_res     = busy;
        o_result.done_res     = done;
        o_result.read_byte    = n.shift;
        o_result.ack_received = n.ack;

        // slot count and end of command, scl falls after a start
        if (done) begin
            if (n.cmd == OP_START) begin
                n.scl = 1'b0;
            end
            n.cmd  = OP_IDLE;
            n.slot = 5'd0;
        end else if (busy) begin
            n.slot = n.slot + 5'd1;
        end

        o_state = n;
    end

endmodule

[design/i2c_master_bit_engine_core.sv]
// top level of the i2c master bit engine: slot stream in, pin levels out
//
// channel   dir  fields (tdata, lowest bit first)
// s_axis    in   cmd_valid[0] op[3:1] write_data[11:4] ack_bit[12] sda_in[13], zero pad
// m_axis    out  scl_level[0] sda_level[1] sda_drive[2] busy_res[3] done_res[4]
//                read_byte[12:5] ack_received[13], zero pad
//
// one word per cycle unless m_axis stalls: each accepted slot word updates
// the engine state and loads the result register in the same edge.
// the result register frees itself when taken, so a new word is accepted
// in the cycle its predecessor's result leaves.
// reset (i_rst_n low, synchronous) leaves the bus idle: scl, sda high and driven.
`timescale 1ns / 1ps

module i2c_master_bit_engine_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [i2cbe_pkg::IN_W-1:0]   s_axis_tdata,  // cmd_valid, op, write_data, ack_bit, sda_in
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [i2cbe_pkg::OUT_W-1:0]  m_axis_tdata   // scl, sda, drive, busy, done, read_byte, ack
);
    import i2cbe_pkg::*;

    t_state   r_state;
    t_state   n_state;
    t_slot_in w_slot;
    t_result  w_result;
    logic     r_out_valid;
    t_result  r_out;
    logic     w_accept;

    // unpack the input word
    assign w_slot = s_axis_tdata[$bits(t_slot_in)-1:0];

    i2cbe_step u_step (
        .i_state  (r_state),
        .i_slot   (w_slot),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // accept while the result register is empty or being emptied
    assign s_axis_tready = ~r_out_valid | m_axis_tready;
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    // engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cmd    <= OP_IDLE;
            r_state.slot   <= 5'd0;
            r_state.phase  <= PH_SETUP;
            r_state.shift  <= 8'd0;
            r_state.tx     <= 8'd0;
            r_state.scl    <= 1'b1;
            r_state.sda    <= 1'b1;
            r_state.sda_en <= 1'b1;
            r_state.ack    <= 1'b0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W - $bits(t_result)){1'b0}}, r_out};

endmodule
